// File: rtl/smdst_pkg.sv
// ---------------------------------------------------------------------------
// smdst_pkg
// shared types and constants of the dual stack over one word store
// ---------------------------------------------------------------------------
package smdst_pkg;

	// number of words in the shared store
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		ACT_PUSH_LO = 3'd0,
		ACT_PUSH_HI = 3'd1,
		ACT_POP_LO  = 3'd2,
		ACT_POP_HI  = 3'd3,
		ACT_DUMP_LO = 3'd4,
		ACT_DUMP_HI = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]               action;
		logic signed [WORD_W-1:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		status_t                  status;
		logic                     last;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic legal;
		logic out_free;
		logic final_one;
	} dp_stat_t;

endpackage

// File: rtl/smdst_ctrl.sv
// ---------------------------------------------------------------------------
// smdst_ctrl
// controller: takes one item, then steps its results out one by one
// ---------------------------------------------------------------------------
module smdst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  smdst_pkg::dp_stat_t stat,
	output smdst_pkg::dp_cmd_t  cmd
);
	import smdst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd.start = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// unused action codes are taken and dropped
				if (cmd_valid && stat.legal) begin
					cmd.start = 1'b1;
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.final_one) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/smdst_dpath.sv
// ---------------------------------------------------------------------------
// smdst_dpath
// datapath: word store, stack counts, read pointer and result register
// ---------------------------------------------------------------------------
module smdst_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smdst_pkg::cmd_item_t cmd_data,
	input  smdst_pkg::dp_cmd_t   cmd,
	output smdst_pkg::dp_stat_t  stat,
	output logic                 res_valid,
	input  logic                 res_ready,
	output smdst_pkg::res_item_t res_data
);
	import smdst_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic [CNT_W-1:0]  low_cnt_q, high_cnt_q;
	logic [CNT_W-1:0]  low_nxt, high_nxt;
	logic [CNT_W:0]    fill;
	logic              full;
	logic              legal;

	logic              use_mem_q, use_mem_nxt;
	status_t           st_q, st_nxt;
	logic [CNT_W-1:0]  rem_q, rem_nxt;
	logic [ADDR_W-1:0] ptr_q, ptr_step;
	logic              up_q, up_nxt;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              start_rd;
	logic [ADDR_W-1:0] start_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	logic              res_valid_q;
	res_item_t         res_q;

	assign fill = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
	assign full = (fill >= (CNT_W + 1)'(DEPTH));

	// decode of the accepted item
	always_comb begin
		low_nxt     = low_cnt_q;
		high_nxt    = high_cnt_q;
		st_nxt      = ST_OK;
		use_mem_nxt = 1'b0;
		rem_nxt     = CNT_W'(1);
		up_nxt      = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		start_rd    = 1'b0;
		start_addr  = '0;
		legal       = 1'b1;
		unique case (cmd_data.action)
			ACT_PUSH_LO: begin
				if (full) begin
					st_nxt = ST_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					wr_addr = low_cnt_q[ADDR_W-1:0];
					low_nxt = low_cnt_q + CNT_W'(1);
				end
			end
			ACT_PUSH_HI: begin
				if (full) begin
					st_nxt = ST_OVERFLOW;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = ADDR_W'(DEPTH - 1) - high_cnt_q[ADDR_W-1:0];
					high_nxt = high_cnt_q + CNT_W'(1);
				end
			end
			ACT_POP_LO: begin
				if (low_cnt_q == '0) begin
					st_nxt = ST_UNDERFLOW;
				end else begin
					low_nxt     = low_cnt_q - CNT_W'(1);
					start_rd    = 1'b1;
					start_addr  = low_nxt[ADDR_W-1:0];
					use_mem_nxt = 1'b1;
				end
			end
			ACT_POP_HI: begin
				if (high_cnt_q == '0) begin
					st_nxt = ST_UNDERFLOW;
				end else begin
					high_nxt    = high_cnt_q - CNT_W'(1);
					start_rd    = 1'b1;
					start_addr  = ADDR_W'(CNT_W'(DEPTH) - high_cnt_q);
					use_mem_nxt = 1'b1;
				end
			end
			ACT_DUMP_LO: begin
				if (low_cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else begin
					start_rd    = 1'b1;
					start_addr  = ADDR_W'(low_cnt_q - CNT_W'(1));
					use_mem_nxt = 1'b1;
					rem_nxt     = low_cnt_q;
				end
			end
			ACT_DUMP_HI: begin
				if (high_cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else begin
					start_rd    = 1'b1;
					start_addr  = ADDR_W'(CNT_W'(DEPTH) - high_cnt_q);
					use_mem_nxt = 1'b1;
					rem_nxt     = high_cnt_q;
					up_nxt      = 1'b1;
				end
			end
			default: begin
				legal = 1'b0;
			end
		endcase
	end

	assign stat.legal     = legal;
	assign ptr_step       = up_q ? (ptr_q + ADDR_W'(1)) : (ptr_q - ADDR_W'(1));
	assign stat.final_one = (rem_q == CNT_W'(1));
	assign stat.out_free  = !res_valid_q || res_ready;

	assign rd_en   = (cmd.start && start_rd) || (cmd.emit && !stat.final_one);
	assign rd_addr = cmd.start ? start_addr : ptr_step;

	// word store, registered read
	always_ff @(posedge clk) begin
		if (cmd.start && wr_en) begin
			mem[wr_addr] <= cmd_data.push_value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_cnt_q   <= '0;
			high_cnt_q  <= '0;
			rem_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				low_cnt_q  <= low_nxt;
				high_cnt_q <= high_nxt;
				rem_q      <= rem_nxt;
			end else if (cmd.emit) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			use_mem_q <= use_mem_nxt;
			st_q      <= st_nxt;
			up_q      <= up_nxt;
			ptr_q     <= start_addr;
		end else if (cmd.emit && !stat.final_one) begin
			ptr_q <= ptr_step;
		end
		if (cmd.emit) begin
			res_q.value  <= use_mem_q ? rdata_q : '0;
			res_q.status <= st_q;
			res_q.last   <= stat.final_one;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// File: rtl/shared_memory_dual_stack.sv
// ---------------------------------------------------------------------------
// shared_memory_dual_stack
// two stacks sharing one word store, low stack grows up, high stack down
// ---------------------------------------------------------------------------
// Each command transfer carries one action: push to the low or high stack,
// pop either stack, or dump either stack from top to bottom. A push gives a
// single result (ok, or overflow when the two stacks together fill the
// store), a pop gives the top word or underflow, a dump gives one result per
// word with last set on the bottom word, or a single empty result. Action
// codes six and seven are taken and produce nothing. A command is first
// accepted and updates the store, then the result register is loaded. A
// dump gives one word per cycle when results are taken at once, through the
// single registered read port of the store. The result register lets the
// next command be taken while the final result of the previous one still
// waits for res_ready. Store contents are not cleared at reset; only written
// words are ever read.
// ---------------------------------------------------------------------------
module shared_memory_dual_stack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  smdst_pkg::cmd_item_t cmd_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output smdst_pkg::res_item_t res_data
);
	import smdst_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// controller: idle / emitting results
	smdst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// datapath: store, counts, dump pointer, result register
	smdst_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

// File: rtl/smdst_chk.sv
// ---------------------------------------------------------------------------
// smdst_chk
// port level checks of the dual stack, bound to the top level
// ---------------------------------------------------------------------------
module smdst_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input smdst_pkg::cmd_item_t cmd_data,
	input logic                 res_valid,
	input logic                 res_ready,
	input smdst_pkg::res_item_t res_data
);
	import smdst_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// error results carry no word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ST_OK |-> res_data.value == '0)
		else $error("non-ok result with non-zero value");

	// error results are always the only result of their command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ST_OK |-> res_data.last)
		else $error("non-ok result without last");

	// no new command while a dump is still part way through
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |-> !cmd_ready)
		else $error("command taken during a dump");

endmodule

bind shared_memory_dual_stack smdst_chk u_smdst_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the dual stack over one shared word store
// ---------------------------------------------------------------------------
// A directed table covers empty stacks, spare action codes, extreme words and
// short dumps. Random segments follow: fills past a full store, drains past
// empty, dumps of deep stacks, spare codes and mixed traffic. Every accepted
// command runs through a local stack mirror, and each result transfer is
// compared field by field with the oldest pending result. Both sides idle
// at random in two of three phases. The receiver also holds off for one long
// stretch, and the sender waits for the block to drain at a few points.
// ---------------------------------------------------------------------------
module tb_top;
	import smdst_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int RAND_ITEMS   = 350;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_AT      = 180;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_A_END  = 140;
	localparam int PHASE_B_END  = 260;

	// codes outside the action set, taken by the block and dropped
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	typedef enum int {SEG_FILL, SEG_DRAIN, SEG_DUMP, SEG_NOISE, SEG_MIX} seg_kind_t;

	typedef struct {
		cmd_item_t cmd;
		bit        typed;
		res_item_t want;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd_data  = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res_data;

	// mirror of the block state
	logic [WORD_W-1:0] stack_mirror [DEPTH];
	int unsigned       lo_fill = 0;
	int unsigned       hi_fill = 0;

	// results of the latest command, then everything still owed by the block
	res_item_t step_out[$];
	res_item_t pending_results[$];
	dir_row_t  dir_tab[$];

	int errors      = 0;
	int cmds_taken  = 0;
	int tx_idle_pct = 23;
	int rx_idle_pct = 75;

	shared_memory_dual_stack dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data (cmd_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic res_item_t mk_res(logic [WORD_W-1:0] v, status_t s, logic l);
		res_item_t r;
		r.value  = v;
		r.status = s;
		r.last   = l;
		return r;
	endfunction

	function automatic cmd_item_t mk_cmd(logic [2:0] a, logic [WORD_W-1:0] v);
		cmd_item_t c;
		c.action     = a;
		c.push_value = v;
		return c;
	endfunction

	// mostly uniform words, now and then one of the extremes
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
		0: return 32'h7fff_ffff;
		1: return 32'h8000_0000;
		2: return 32'hffff_ffff;
		3: return 32'h0000_0000;
		default: return $urandom;
		endcase
	endfunction

	// one command against the mirror, results left in step_out
	function automatic void apply_action(cmd_item_t c);
		bit          full;
		int unsigned i;
		full = (lo_fill + hi_fill) >= DEPTH;
		step_out.delete();
		case (c.action)
		ACT_PUSH_LO: begin
			if (full) begin
				step_out.push_back(mk_res('0, ST_OVERFLOW, 1'b1));
			end else begin
				stack_mirror[lo_fill] = c.push_value;
				lo_fill++;
				step_out.push_back(mk_res('0, ST_OK, 1'b1));
			end
		end
		ACT_PUSH_HI: begin
			if (full) begin
				step_out.push_back(mk_res('0, ST_OVERFLOW, 1'b1));
			end else begin
				hi_fill++;
				stack_mirror[DEPTH - hi_fill] = c.push_value;
				step_out.push_back(mk_res('0, ST_OK, 1'b1));
			end
		end
		ACT_POP_LO: begin
			if (lo_fill == 0) begin
				step_out.push_back(mk_res('0, ST_UNDERFLOW, 1'b1));
			end else begin
				lo_fill--;
				step_out.push_back(mk_res(stack_mirror[lo_fill], ST_OK, 1'b1));
			end
		end
		ACT_POP_HI: begin
			if (hi_fill == 0) begin
				step_out.push_back(mk_res('0, ST_UNDERFLOW, 1'b1));
			end else begin
				step_out.push_back(mk_res(stack_mirror[DEPTH - hi_fill], ST_OK, 1'b1));
				hi_fill--;
			end
		end
		ACT_DUMP_LO: begin
			if (lo_fill == 0) begin
				step_out.push_back(mk_res('0, ST_EMPTY, 1'b1));
			end else begin
				for (i = 0; i < lo_fill; i++)
					step_out.push_back(mk_res(stack_mirror[lo_fill - 1 - i], ST_OK,
						i == lo_fill - 1));
			end
		end
		ACT_DUMP_HI: begin
			if (hi_fill == 0) begin
				step_out.push_back(mk_res('0, ST_EMPTY, 1'b1));
			end else begin
				for (i = 0; i < hi_fill; i++)
					step_out.push_back(mk_res(stack_mirror[DEPTH - hi_fill + i], ST_OK,
						i == hi_fill - 1));
			end
		end
		default: begin
		end
		endcase
	endfunction

	task automatic add_row(input logic [2:0] a, input logic [WORD_W-1:0] v, input bit typed,
			input logic [WORD_W-1:0] wv, input status_t ws);
		dir_row_t r;
		r.cmd   = mk_cmd(a, v);
		r.typed = typed;
		r.want  = mk_res(wv, ws, 1'b1);
		dir_tab.push_back(r);
	endtask

	// offer one command, hold it until the transfer, then book its results
	task automatic offer(input cmd_item_t c, input bit typed, input res_item_t want);
		// idling mix follows how far the run has got
		if (cmds_taken < PHASE_A_END) begin
			tx_idle_pct = 23;
			rx_idle_pct = 75;
		end else if (cmds_taken < PHASE_B_END) begin
			tx_idle_pct = 75;
			rx_idle_pct = 23;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= c;
		do @(posedge clk); while (!cmd_ready);
		apply_action(c);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (step_out[k])
				pending_results.push_back(step_out[k]);
		cmds_taken++;
	endtask

	// stop offering until every owed result has come out
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic cmp_field(input string fname, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	// -------------------------------------------------------------------
	// command side
	// -------------------------------------------------------------------
	initial begin
		seg_kind_t   kind;
		int          seg_len;
		int          n;
		int          rand_taken;
		bit          mid_pause_done;
		bit          side;
		logic [2:0]  act;
		res_item_t   none;

		rand_taken     = 0;
		mid_pause_done = 1'b0;
		none           = '0;

		// empty stacks straight after reset, spare codes, extreme words, short dumps
		add_row(ACT_POP_LO,  32'hffff_ffff, 1'b1, 32'h0, ST_UNDERFLOW);
		add_row(ACT_POP_HI,  32'h0000_0000, 1'b1, 32'h0, ST_UNDERFLOW);
		add_row(ACT_DUMP_LO, 32'h1234_5678, 1'b1, 32'h0, ST_EMPTY);
		add_row(ACT_DUMP_HI, 32'h8765_4321, 1'b1, 32'h0, ST_EMPTY);
		add_row(ACT_SPARE_6, 32'hdead_beef, 1'b0, 32'h0, ST_OK);
		add_row(ACT_SPARE_7, 32'hffff_ffff, 1'b0, 32'h0, ST_OK);
		add_row(ACT_PUSH_LO, 32'h7fff_ffff, 1'b1, 32'h0, ST_OK);
		add_row(ACT_PUSH_LO, 32'h8000_0000, 1'b1, 32'h0, ST_OK);
		add_row(ACT_PUSH_LO, 32'h0000_0000, 1'b1, 32'h0, ST_OK);
		add_row(ACT_PUSH_HI, 32'hffff_ffff, 1'b1, 32'h0, ST_OK);
		add_row(ACT_PUSH_HI, 32'h0000_0001, 1'b1, 32'h0, ST_OK);
		add_row(ACT_DUMP_LO, 32'h0000_0000, 1'b0, 32'h0, ST_OK);
		add_row(ACT_DUMP_HI, 32'h0000_0000, 1'b0, 32'h0, ST_OK);
		add_row(ACT_POP_LO,  32'h5555_5555, 1'b1, 32'h0000_0000, ST_OK);
		add_row(ACT_POP_HI,  32'haaaa_aaaa, 1'b1, 32'h0000_0001, ST_OK);
		add_row(ACT_POP_LO,  32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK);
		add_row(ACT_POP_HI,  32'h0000_0000, 1'b1, 32'hffff_ffff, ST_OK);
		add_row(ACT_POP_HI,  32'h0000_0000, 1'b1, 32'h0, ST_UNDERFLOW);
		add_row(ACT_DUMP_HI, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY);
		add_row(ACT_DUMP_LO, 32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK);
		add_row(ACT_POP_LO,  32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK);
		add_row(ACT_POP_LO,  32'h0000_0000, 1'b1, 32'h0, ST_UNDERFLOW);
		add_row(ACT_PUSH_HI, 32'ha5a5_a5a5, 1'b1, 32'h0, ST_OK);
		add_row(ACT_PUSH_LO, 32'h5a5a_5a5a, 1'b1, 32'h0, ST_OK);
		add_row(ACT_DUMP_HI, 32'h0000_0000, 1'b0, 32'h0, ST_OK);

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (dir_tab[r])
			offer(dir_tab[r].cmd, dir_tab[r].typed, dir_tab[r].want);

		// let everything from the table come out before the random part
		wait_drained();

		while (rand_taken < RAND_ITEMS) begin
			// one more full drain halfway through
			if (!mid_pause_done && rand_taken >= RAND_ITEMS / 2) begin
				wait_drained();
				mid_pause_done = 1'b1;
			end
			n = $urandom_range(0, 99);
			if (n < 8)
				kind = SEG_FILL;
			else if (n < 16)
				kind = SEG_DRAIN;
			else if (n < 28)
				kind = SEG_DUMP;
			else if (n < 34)
				kind = SEG_NOISE;
			else
				kind = SEG_MIX;

			case (kind)
			SEG_FILL: begin
				// push past a full store so overflow shows up
				seg_len = DEPTH - int'(lo_fill + hi_fill) + $urandom_range(1, 3);
				for (n = 0; n < seg_len; n++) begin
					act = $urandom_range(0, 1) ? ACT_PUSH_HI : ACT_PUSH_LO;
					offer(mk_cmd(act, rand_word()), 1'b0, none);
					rand_taken++;
				end
			end
			SEG_DRAIN: begin
				// empty one side, then pop it once or twice more
				side    = 1'($urandom_range(0, 1));
				seg_len = int'(side ? hi_fill : lo_fill) + $urandom_range(1, 2);
				for (n = 0; n < seg_len; n++) begin
					offer(mk_cmd(side ? ACT_POP_HI : ACT_POP_LO, rand_word()), 1'b0, none);
					rand_taken++;
				end
			end
			SEG_DUMP: begin
				act = $urandom_range(0, 1) ? ACT_DUMP_HI : ACT_DUMP_LO;
				offer(mk_cmd(act, rand_word()), 1'b0, none);
				rand_taken++;
			end
			SEG_NOISE: begin
				// spare codes give nothing back, so they are not counted
				act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
				offer(mk_cmd(act, rand_word()), 1'b0, none);
			end
			default: begin
				seg_len = $urandom_range(4, 16);
				for (n = 0; n < seg_len; n++) begin
					act = 3'($urandom_range(0, 5));
					offer(mk_cmd(act, rand_word()), 1'b0, none);
					rand_taken++;
				end
			end
			endcase
		end

		// drain, then watch a while longer for stray results
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// -------------------------------------------------------------------
	// result side
	// -------------------------------------------------------------------
	initial begin
		int        hold_left;
		bit        hold_done;
		res_item_t exp_res;

		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing pending, expected none, actual %0h/%0d/%0b",
						$time, res_data.value, res_data.status, res_data.last);
				end else begin
					exp_res = pending_results.pop_front();
					cmp_field("value",  exp_res.value,  res_data.value);
					cmp_field("status", WORD_W'(exp_res.status), WORD_W'(res_data.status));
					cmp_field("last",   WORD_W'(exp_res.last),   WORD_W'(res_data.last));
				end
			end
			// one long hold-off so the block backs up and stalls its command side
			if (!hold_done && cmds_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// -------------------------------------------------------------------
	// watchdog
	// -------------------------------------------------------------------
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: cycle limit reached, %0d results still pending",
			$time, pending_results.size());
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
